// ===== sv/ride_pkg.sv =====
// Package: shared constants, types and digit encoding for the radix digit emitter.
package ride_pkg;

    localparam int VALUE_BITS_DEF = 64;

    localparam logic [7:0] FMT_NUL   = 8'h00;
    localparam logic [7:0] FMT_DEC_D = 8'h64;
    localparam logic [7:0] FMT_DEC_U = 8'h75;
    localparam logic [7:0] FMT_OCT_L = 8'h6F;
    localparam logic [7:0] FMT_OCT_U = 8'h4F;
    localparam logic [7:0] FMT_HEX_L = 8'h78;
    localparam logic [7:0] FMT_HEX_U = 8'h58;
    localparam logic [7:0] FMT_BIN_L = 8'h62;
    localparam logic [7:0] FMT_BIN_U = 8'h42;

    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_LOW_A = 8'h61;
    localparam logic [7:0] CHR_UP_A  = 8'h41;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DABBLE,
        ST_SKIP,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        RAD_2,
        RAD_8,
        RAD_10,
        RAD_16
    } t_radix;

    function automatic logic [7:0] f_ascii(input logic [3:0] d, input logic lower);
        logic [7:0] base;
        base = lower ? CHR_LOW_A : CHR_UP_A;
        if (d < 4'd10) begin
            f_ascii = CHR_ZERO + {4'b0, d};
        end else begin
            f_ascii = base + {4'b0, d} - 8'd10;
        end
    endfunction

endpackage

// ===== sv/ride_if.sv =====
// Interfaces: input item channel and digit result channel.
interface ride_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic        is_signed;
    logic [7:0]  format_char;

    modport source (output valid, output value, output is_signed, output format_char,
                     input ready);
    modport sink   (input valid, input value, input is_signed, input format_char,
                     output ready);
endinterface

interface ride_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] digit_char;
    logic       negative;
    logic       status;
    logic       last_digit;

    modport source (output valid, output digit_char, output negative, output status,
                     output last_digit, input ready);
    modport sink   (input valid, input digit_char, input negative, input status,
                     input last_digit, output ready);
endinterface

// ===== sv/integer_radix_digit_emitter.sv =====
// Top level: converts one integer to ASCII digits in the selected radix.
//
//  channel | dir | transfer when         | payload
//  i_in    | in  | i_in.valid & ready    | value, is_signed, format_char
//  o_out   | out | o_out.valid & ready   | digit_char, negative, status, last_digit
//
// One item at a time; i_in.ready is high only between items.
// Decimal: VALUE_BITS shift-add-3 steps on the shared BCD register, then emit.
// All radixes: leading zero digits are skipped, then the digits are emitted most
// significant first, one per o_out transfer; unknown format: accept plus one error
// digit.
// Output stalls hold the current digit. Synchronous active-low reset to idle.
module integer_radix_digit_emitter #(
    parameter int VALUE_BITS = ride_pkg::VALUE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ride_in_if.sink       i_in,
    ride_out_if.source    o_out
);

    localparam int NDEC = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int BW   = NDEC * 4;
    localparam int N8   = (VALUE_BITS + 2) / 3;
    localparam int N16  = (VALUE_BITS + 3) / 4;
    localparam int SH2  = BW - VALUE_BITS;
    localparam int SH8  = BW - 3 * N8;
    localparam int SH16 = BW - 4 * N16;
    localparam int CW   = $clog2(VALUE_BITS + 1);

    ride_pkg::t_state r_state, n_state;
    ride_pkg::t_radix r_radix, n_radix;
    logic             r_lower, n_lower;
    logic             r_neg, n_neg;
    logic             r_err, n_err;
    logic [BW-1:0]    r_buf, n_buf;
    logic [VALUE_BITS-1:0] r_bin, n_bin;
    logic [CW-1:0]    r_cnt, n_cnt;

    logic                  in_xfer;
    logic                  out_xfer;
    logic [VALUE_BITS-1:0] in_val;
    logic                  in_neg;
    logic [VALUE_BITS-1:0] in_mag;
    logic [BW-1:0]         in_ext;
    ride_pkg::t_radix      in_radix;
    logic                  in_err;
    logic [3:0]            top_dig;
    logic [BW-1:0]         buf_shift;
    logic [BW-1:0]         dab_adj;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = o_out.valid && o_out.ready;
    assign in_val   = i_in.value[VALUE_BITS-1:0];
    assign in_neg   = i_in.is_signed && in_val[VALUE_BITS-1];
    assign in_mag   = in_neg ? (~in_val + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : in_val;
    assign in_ext   = {{(BW-VALUE_BITS){1'b0}}, in_mag};

    always_comb begin
        in_radix = ride_pkg::RAD_10;
        in_err   = 1'b0;
        unique case (i_in.format_char) inside
            ride_pkg::FMT_NUL, ride_pkg::FMT_DEC_D, ride_pkg::FMT_DEC_U:
                in_radix = ride_pkg::RAD_10;
            ride_pkg::FMT_OCT_L, ride_pkg::FMT_OCT_U:
                in_radix = ride_pkg::RAD_8;
            ride_pkg::FMT_HEX_L, ride_pkg::FMT_HEX_U:
                in_radix = ride_pkg::RAD_16;
            ride_pkg::FMT_BIN_L, ride_pkg::FMT_BIN_U:
                in_radix = ride_pkg::RAD_2;
            default:
                in_err = 1'b1;
        endcase
    end

    // top digit and digit-wide shift of the buffer
    always_comb begin
        unique case (r_radix)
            ride_pkg::RAD_2: begin
                top_dig   = {3'b0, r_buf[BW-1]};
                buf_shift = r_buf << 1;
            end
            ride_pkg::RAD_8: begin
                top_dig   = {1'b0, r_buf[BW-1 -: 3]};
                buf_shift = r_buf << 3;
            end
            default: begin
                top_dig   = r_buf[BW-1 -: 4];
                buf_shift = r_buf << 4;
            end
        endcase
    end

    // shift-add-3 correction on every BCD nibble
    always_comb begin
        for (int j = 0; j < NDEC; j++) begin
            dab_adj[4*j +: 4] = (r_buf[4*j +: 4] >= 4'd5) ? r_buf[4*j +: 4] + 4'd3
                                                           : r_buf[4*j +: 4];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ride_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if (in_err) begin
                        n_state = ride_pkg::ST_EMIT;
                    end else if (in_radix == ride_pkg::RAD_10) begin
                        n_state = ride_pkg::ST_DABBLE;
                    end else begin
                        n_state = ride_pkg::ST_SKIP;
                    end
                end
            end
            ride_pkg::ST_DABBLE: begin
                if (r_cnt == CW'(1)) begin
                    n_state = ride_pkg::ST_SKIP;
                end
            end
            ride_pkg::ST_SKIP: begin
                if (top_dig != 4'd0 || r_cnt == CW'(1)) begin
                    n_state = ride_pkg::ST_EMIT;
                end
            end
            ride_pkg::ST_EMIT: begin
                if (out_xfer && r_cnt == CW'(1)) begin
                    n_state = ride_pkg::ST_IDLE;
                end
            end
            default: n_state = ride_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready       = (r_state == ride_pkg::ST_IDLE);
        o_out.valid      = (r_state == ride_pkg::ST_EMIT);
        o_out.digit_char = r_err ? 8'h00 : ride_pkg::f_ascii(top_dig, r_lower);
        o_out.negative   = r_neg;
        o_out.status     = r_err;
        o_out.last_digit = (r_cnt == CW'(1));
    end

    always_comb begin
        n_radix = r_radix;
        n_lower = r_lower;
        n_neg   = r_neg;
        n_err   = r_err;
        n_buf   = r_buf;
        n_bin   = r_bin;
        n_cnt   = r_cnt;
        unique case (r_state)
            ride_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_radix = in_radix;
                    n_lower = (i_in.format_char == ride_pkg::FMT_HEX_L);
                    n_err   = in_err;
                    n_neg   = in_neg && !in_err;
                    n_bin   = in_mag;
                    if (in_err) begin
                        n_cnt = CW'(1);
                    end else begin
                        unique case (in_radix)
                            ride_pkg::RAD_2: begin
                                n_buf = in_ext << SH2;
                                n_cnt = CW'(VALUE_BITS);
                            end
                            ride_pkg::RAD_8: begin
                                n_buf = in_ext << SH8;
                                n_cnt = CW'(N8);
                            end
                            ride_pkg::RAD_16: begin
                                n_buf = in_ext << SH16;
                                n_cnt = CW'(N16);
                            end
                            default: begin
                                n_buf = '0;
                                n_cnt = CW'(VALUE_BITS);
                            end
                        endcase
                    end
                end
            end
            ride_pkg::ST_DABBLE: begin
                n_buf = {dab_adj[BW-2:0], r_bin[VALUE_BITS-1]};
                n_bin = r_bin << 1;
                n_cnt = (r_cnt == CW'(1)) ? CW'(NDEC) : r_cnt - CW'(1);
            end
            ride_pkg::ST_SKIP: begin
                if (top_dig == 4'd0 && r_cnt != CW'(1)) begin
                    n_buf = buf_shift;
                    n_cnt = r_cnt - CW'(1);
                end
            end
            ride_pkg::ST_EMIT: begin
                if (out_xfer) begin
                    n_buf = buf_shift;
                    n_cnt = r_cnt - CW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ride_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_err   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_err   <= n_err;
        end
        r_radix <= n_radix;
        r_lower <= n_lower;
        r_neg   <= n_neg;
        r_buf   <= n_buf;
        r_bin   <= n_bin;
    end

endmodule
